FILE: design/pbc_pkg.sv
// Shared types and constants for the pairwise box collision response core.
// Depends on nothing; imported by pbc_sqrt, pbc_div and the core module.
package pbc_pkg;

    localparam int MAX_BODIES_DEF = 32;

    localparam int NORM_SHIFT = 30;
    localparam int W_SHIFT    = 28;

    localparam int SQ_IW = 64;
    localparam int SQ_OW = 32;

    localparam int DIV_DW = 61;
    localparam int DIV_QW = 31;
    localparam int DIV_VW = 32;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [30:0] mass;
        logic [30:0] hw;
        logic [30:0] hh;
    } body_t;

endpackage

FILE: design/pbc_ram.sv
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module pbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/pbc_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on pbc_pkg for its widths.
module pbc_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pbc_pkg::SQ_IW-1:0] radicand,
    output logic                      busy,
    output logic                      done,
    output logic [pbc_pkg::SQ_OW-1:0] root
);

    import pbc_pkg::*;

    localparam int RW = SQ_OW + 2;
    localparam int CNTW = $clog2(SQ_OW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [SQ_IW-1:0] rad_reg;
    logic [RW-1:0]   rem_reg;
    logic [SQ_OW-1:0] root_reg;

    logic [RW+1:0] rem_t;
    logic [RW+1:0] trial;
    logic          ge;

    assign rem_t = {rem_reg, rad_reg[SQ_IW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(SQ_OW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[SQ_IW-3:0], 2'b00};
            if (ge)
            begin
                rem_reg  <= RW'(rem_t - trial);
                root_reg <= {root_reg[SQ_OW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= RW'(rem_t);
                root_reg <= {root_reg[SQ_OW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: design/pbc_div.sv
// Restoring radix-2 divider for quotients known to fit in QW bits.
// Depends on pbc_pkg for its default widths.
module pbc_div #(
    parameter int DW = pbc_pkg::DIV_DW,
    parameter int QW = pbc_pkg::DIV_QW,
    parameter int VW = pbc_pkg::DIV_VW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [QW-1:0] quotient
);

    import pbc_pkg::*;

    localparam int CNTW = $clog2(QW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [VW-1:0]   rem_reg;
    logic [QW-1:0]   quo_reg;
    logic [VW-1:0]   dvs_reg;

    logic [VW:0] t;
    logic        ge;

    assign t  = {rem_reg, quo_reg[QW-1]};
    assign ge = (t >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= VW'(dividend[DW-1:QW]);
            quo_reg <= dividend[QW-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= VW'(t - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= VW'(t);
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/pairwise_box_collision_response_core.sv
// Pairwise box collision response core: body store, pair sequencer, shared multiplier.
// Depends on pbc_pkg, pbc_ram, pbc_sqrt and pbc_div.
//
// Usage: drive a command word with start high; it is taken on an edge where busy is
// low. A load word (req_type 0) writes one body into slot body_index in that same
// cycle and leaves busy low; a slot at or beyond MAX_BODIES is ignored. A run word
// (req_type 1) raises busy, visits every pair of the first body_count bodies in order,
// updates velocities in the store, then reports each body's velocity, one word per
// out_valid pulse, in index order, last_body marking the final word. busy falls as
// the last word is shown. body_count 0 gives no words.
// A separated pair ends at the overlap check; an overlapping pair also runs the
// bit-serial square root, the radix-2 dividers and the single shared multiplier (22
// steps). Readout reads one body at a time from the one store read port. The
// receiver cannot stall: each word lasts one cycle.
// Reset clears the control state; the store holds unknown data until loaded.
module pairwise_box_collision_response_core #(
    parameter int MAX_BODIES = pbc_pkg::MAX_BODIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [4:0]         body_index,
    input  logic [5:0]         body_count,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic [30:0]        mass,
    input  logic [30:0]        half_width,
    input  logic [30:0]        half_height,
    output logic               out_valid,
    output logic [4:0]         out_index,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic               last_body
);

    import pbc_pkg::*;

    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);

    localparam logic [4:0] ST_SQ_X = 5'd0;
    localparam logic [4:0] ST_SQ_Y = 5'd1;
    localparam logic [4:0] ST_AN_X = 5'd2;
    localparam logic [4:0] ST_AN_Y = 5'd3;
    localparam logic [4:0] ST_AT_X = 5'd4;
    localparam logic [4:0] ST_AT_Y = 5'd5;
    localparam logic [4:0] ST_BN_X = 5'd6;
    localparam logic [4:0] ST_BN_Y = 5'd7;
    localparam logic [4:0] ST_BT_X = 5'd8;
    localparam logic [4:0] ST_BT_Y = 5'd9;
    localparam logic [4:0] ST_MA_0 = 5'd10;
    localparam logic [4:0] ST_MA_1 = 5'd11;
    localparam logic [4:0] ST_MB_0 = 5'd12;
    localparam logic [4:0] ST_MB_1 = 5'd13;
    localparam logic [4:0] ST_XA_0 = 5'd14;
    localparam logic [4:0] ST_XA_1 = 5'd15;
    localparam logic [4:0] ST_YA_0 = 5'd16;
    localparam logic [4:0] ST_YA_1 = 5'd17;
    localparam logic [4:0] ST_XB_0 = 5'd18;
    localparam logic [4:0] ST_XB_1 = 5'd19;
    localparam logic [4:0] ST_YB_0 = 5'd20;
    localparam logic [4:0] ST_YB_1 = 5'd21;

    localparam logic signed [67:0] LIM_POS = 68'sh0_0000_0001_0000_0000;
    localparam logic signed [67:0] LIM_NEG = -68'sh0_0000_0001_0000_0000;
    localparam logic signed [67:0] S32_MAX = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [67:0] S32_MIN = -68'sh0_0000_0000_8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_GEOM,
        S_CHK,
        S_NORM,
        S_MAC,
        S_SQGO,
        S_SQRT,
        S_DIVN,
        S_DIVNW,
        S_WB_A,
        S_WB_B,
        S_NEXT,
        S_OUT_RD,
        S_OUT_EMIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [CW-1:0] i_reg, j_reg, k_reg, n_reg;
    logic [4:0]    stp_reg;
    logic          ph_reg;
    logic          wpend_reg;
    logic          out_valid_reg;

    body_t rec_a_reg, rec_b_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [32:0]        ux_reg, uy_reg;
    logic               sgx_reg, sgy_reg;
    logic signed [66:0] prod_reg;
    logic signed [67:0] acc_reg;
    logic [62:0]        s_reg;
    logic [31:0]        dist_reg;
    logic signed [31:0] nx_reg, ny_reg;
    logic [29:0]        wa_reg, wb_reg;
    logic signed [33:0] van_reg, vat_reg, vbn_reg, vbt_reg, nan_reg, nbn_reg;
    logic signed [31:0] vxa_reg, vya_reg, vxb_reg, vyb_reg;
    logic [4:0]         out_index_reg;
    logic signed [31:0] new_vel_x_reg, new_vel_y_reg;
    logic               last_body_reg;

    logic          ld_acc, run_acc, ld_ok;
    logic [6:0]    cnt_sat;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    body_t         wdata, rdata;

    logic [32:0] ux_c, uy_c;
    logic [31:0] hwsum, hhsum, msum;
    logic        hit;

    logic signed [34:0] mul_a;
    logic signed [31:0] mul_b;
    logic               mul_sub;
    logic signed [67:0] acc_base, prod_ext, sum, sh30, sh28;
    logic signed [67:0] mix_a, mix_b;

    logic               sq_start, sq_busy, sq_done;
    logic [SQ_OW-1:0]   sq_root;
    logic               dv_start;
    logic [DIV_DW-1:0]  dvd0, dvd1;
    logic [DIV_VW-1:0]  dvs;
    logic               dv0_busy, dv0_done, dv1_busy, dv1_done;
    logic [DIV_QW-1:0]  q0, q1;

    assign ld_acc  = (state_reg == S_IDLE) && start && !req_type;
    assign run_acc = (state_reg == S_IDLE) && start && req_type;
    assign ld_ok   = (32'(body_index) < 32'(MAX_BODIES));
    assign cnt_sat = (7'(body_count) > 7'(MAX_BODIES)) ? 7'(MAX_BODIES) : 7'(body_count);

    assign ux_c  = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign uy_c  = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign hwsum = {1'b0, rec_a_reg.hw} + {1'b0, rec_b_reg.hw};
    assign hhsum = {1'b0, rec_a_reg.hh} + {1'b0, rec_b_reg.hh};
    assign msum  = {1'b0, rec_a_reg.mass} + {1'b0, rec_b_reg.mass};
    assign hit   = ({1'b0, hwsum} > ux_c) && ({1'b0, hhsum} > uy_c)
                   && ((ux_c | uy_c) != 33'd0);

    always_comb
    begin
        we    = 1'b0;
        waddr = i_reg[AW-1:0];
        wdata = rec_a_reg;
        raddr = i_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                we    = ld_acc && ld_ok;
                waddr = AW'(body_index);
                wdata = '{pos_x: pos_x, pos_y: pos_y, vel_x: vel_x, vel_y: vel_y,
                          mass: mass, hw: half_width, hh: half_height};
            end
            S_RD_B:
            begin
                raddr = j_reg[AW-1:0];
            end
            S_WB_A:
            begin
                we          = 1'b1;
                wdata       = rec_a_reg;
                wdata.vel_x = vxa_reg;
                wdata.vel_y = vya_reg;
            end
            S_WB_B:
            begin
                we          = 1'b1;
                waddr       = j_reg[AW-1:0];
                wdata       = rec_b_reg;
                wdata.vel_x = vxb_reg;
                wdata.vel_y = vyb_reg;
            end
            S_OUT_RD:
            begin
                raddr = k_reg[AW-1:0];
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    pbc_ram #(
        .WIDTH ($bits(body_t)),
        .DEPTH (MAX_BODIES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sub = 1'b0;
        case (stp_reg)
            ST_SQ_X: begin mul_a = {4'b0, ux_reg[30:0]}; mul_b = {1'b0, ux_reg[30:0]}; end
            ST_SQ_Y: begin mul_a = {4'b0, uy_reg[30:0]}; mul_b = {1'b0, uy_reg[30:0]}; end
            ST_AN_X: begin mul_a = {{3{rec_a_reg.vel_x[31]}}, rec_a_reg.vel_x}; mul_b = nx_reg; end
            ST_AN_Y: begin mul_a = {{3{rec_a_reg.vel_y[31]}}, rec_a_reg.vel_y}; mul_b = ny_reg; end
            ST_AT_X: begin mul_a = {{3{rec_a_reg.vel_y[31]}}, rec_a_reg.vel_y}; mul_b = nx_reg; end
            ST_AT_Y:
            begin
                mul_a   = {{3{rec_a_reg.vel_x[31]}}, rec_a_reg.vel_x};
                mul_b   = ny_reg;
                mul_sub = 1'b1;
            end
            ST_BN_X: begin mul_a = {{3{rec_b_reg.vel_x[31]}}, rec_b_reg.vel_x}; mul_b = nx_reg; end
            ST_BN_Y: begin mul_a = {{3{rec_b_reg.vel_y[31]}}, rec_b_reg.vel_y}; mul_b = ny_reg; end
            ST_BT_X: begin mul_a = {{3{rec_b_reg.vel_y[31]}}, rec_b_reg.vel_y}; mul_b = nx_reg; end
            ST_BT_Y:
            begin
                mul_a   = {{3{rec_b_reg.vel_x[31]}}, rec_b_reg.vel_x};
                mul_b   = ny_reg;
                mul_sub = 1'b1;
            end
            ST_MA_0:
            begin
                mul_a = {vbn_reg[33], vbn_reg} - {van_reg[33], van_reg};
                mul_b = {2'b00, wb_reg};
            end
            ST_MB_0:
            begin
                mul_a = {van_reg[33], van_reg} - {vbn_reg[33], vbn_reg};
                mul_b = {2'b00, wa_reg};
            end
            ST_XA_0: begin mul_a = {nan_reg[33], nan_reg}; mul_b = nx_reg; end
            ST_XA_1: begin mul_a = {vat_reg[33], vat_reg}; mul_b = ny_reg; mul_sub = 1'b1; end
            ST_YA_0: begin mul_a = {nan_reg[33], nan_reg}; mul_b = ny_reg; end
            ST_YA_1: begin mul_a = {vat_reg[33], vat_reg}; mul_b = nx_reg; end
            ST_XB_0: begin mul_a = {nbn_reg[33], nbn_reg}; mul_b = nx_reg; end
            ST_XB_1: begin mul_a = {vbt_reg[33], vbt_reg}; mul_b = ny_reg; mul_sub = 1'b1; end
            ST_YB_0: begin mul_a = {nbn_reg[33], nbn_reg}; mul_b = ny_reg; end
            ST_YB_1: begin mul_a = {vbt_reg[33], vbt_reg}; mul_b = nx_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign acc_base = stp_reg[0] ? acc_reg : '0;
    assign prod_ext = {prod_reg[66], prod_reg};
    assign sum      = mul_sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
    assign sh30     = sum >>> NORM_SHIFT;
    assign sh28     = sum >>> W_SHIFT;
    assign mix_a    = {{34{van_reg[33]}}, van_reg} + sh28;
    assign mix_b    = {{34{vbn_reg[33]}}, vbn_reg} + sh28;

    assign sq_start = (state_reg == S_SQGO);

    pbc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({1'b0, s_reg}),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign dv_start = ((state_reg == S_CHK) && hit && (msum != 32'd0))
                      || ((state_reg == S_DIVN) && !wpend_reg && !dv0_busy && !dv1_busy);
    assign dvd0 = (state_reg == S_CHK) ? DIV_DW'({rec_a_reg.mass, 29'b0})
                                       : DIV_DW'({ux_reg[30:0], 30'b0});
    assign dvd1 = (state_reg == S_CHK) ? DIV_DW'({rec_b_reg.mass, 29'b0})
                                       : DIV_DW'({uy_reg[30:0], 30'b0});
    assign dvs  = (state_reg == S_CHK) ? msum : dist_reg;

    pbc_div #(
        .DW (DIV_DW),
        .QW (DIV_QW),
        .VW (DIV_VW)
    ) u_div0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dvd0),
        .divisor  (dvs),
        .busy     (dv0_busy),
        .done     (dv0_done),
        .quotient (q0)
    );

    pbc_div #(
        .DW (DIV_DW),
        .QW (DIV_QW),
        .VW (DIV_VW)
    ) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dvd1),
        .divisor  (dvs),
        .busy     (dv1_busy),
        .done     (dv1_done),
        .quotient (q1)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (run_acc)
                begin
                    if (cnt_sat == 7'd0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (cnt_sat == 7'd1)
                    begin
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        state_next = S_RD_A;
                    end
                end
            end
            S_RD_A:   state_next = S_RD_B;
            S_RD_B:   state_next = S_GEOM;
            S_GEOM:   state_next = S_CHK;
            S_CHK:    state_next = hit ? S_NORM : S_NEXT;
            S_NORM:
            begin
                if ((ux_reg[32:31] | uy_reg[32:31]) == 2'b00)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (ph_reg && (stp_reg == ST_SQ_Y))
                begin
                    state_next = S_SQGO;
                end
                else if (ph_reg && (stp_reg == ST_YB_1))
                begin
                    state_next = S_WB_A;
                end
            end
            S_SQGO:   state_next = S_SQRT;
            S_SQRT:   state_next = (sq_done && !sq_busy) ? S_DIVN : S_SQRT;
            S_DIVN:
            begin
                state_next = (!wpend_reg && !dv0_busy && !dv1_busy) ? S_DIVNW : S_DIVN;
            end
            S_DIVNW:  state_next = (dv0_done && dv1_done) ? S_MAC : S_DIVNW;
            S_WB_A:   state_next = S_WB_B;
            S_WB_B:   state_next = S_NEXT;
            S_NEXT:
            begin
                if ((({1'b0, j_reg} + 1'b1) < {1'b0, n_reg})
                    || (({1'b0, i_reg} + 2'd2) < {1'b0, n_reg}))
                begin
                    state_next = S_RD_A;
                end
                else
                begin
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD: state_next = S_OUT_EMIT;
            S_OUT_EMIT:
            begin
                state_next = ((k_reg + 1'b1) == n_reg) ? S_IDLE : S_OUT_RD;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            stp_reg       <= ST_SQ_X;
            ph_reg        <= 1'b0;
            wpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            new_vel_x_reg <= '0;
            new_vel_y_reg <= '0;
            last_body_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b0;
            if (dv0_done)
            begin
                wpend_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (run_acc)
                    begin
                        n_reg <= CW'(cnt_sat);
                        i_reg <= '0;
                        j_reg <= CW'(1);
                        k_reg <= '0;
                    end
                end
                S_CHK:
                begin
                    stp_reg <= ST_SQ_X;
                    ph_reg  <= 1'b0;
                    if (hit && (msum != 32'd0))
                    begin
                        wpend_reg <= 1'b1;
                    end
                end
                S_MAC:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        stp_reg <= stp_reg + 1'b1;
                    end
                end
                S_NEXT:
                begin
                    if (({1'b0, j_reg} + 1'b1) < {1'b0, n_reg})
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        j_reg <= i_reg + CW'(2);
                    end
                end
                S_OUT_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    k_reg         <= k_reg + 1'b1;
                    out_index_reg <= 5'(k_reg);
                    new_vel_x_reg <= rdata.vel_x;
                    new_vel_y_reg <= rdata.vel_y;
                    last_body_reg <= ((k_reg + 1'b1) == n_reg);
                end
                default:
                begin
                    ph_reg <= ph_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD_B)
        begin
            rec_a_reg <= rdata;
        end
        if (state_reg == S_GEOM)
        begin
            rec_b_reg <= rdata;
            dx_reg    <= {rec_a_reg.pos_x[31], rec_a_reg.pos_x} - {rdata.pos_x[31], rdata.pos_x};
            dy_reg    <= {rec_a_reg.pos_y[31], rec_a_reg.pos_y} - {rdata.pos_y[31], rdata.pos_y};
        end
        if (state_reg == S_CHK)
        begin
            ux_reg  <= ux_c;
            uy_reg  <= uy_c;
            sgx_reg <= dx_reg[32];
            sgy_reg <= dy_reg[32];
            if (msum == 32'd0)
            begin
                wa_reg <= 30'd1 << W_SHIFT;
                wb_reg <= 30'd1 << W_SHIFT;
            end
        end
        if (state_reg == S_NORM)
        begin
            ux_reg <= ux_reg >> 1;
            uy_reg <= uy_reg >> 1;
            if ((ux_reg[32:31] | uy_reg[32:31]) == 2'b00)
            begin
                ux_reg <= ux_reg;
                uy_reg <= uy_reg;
            end
        end
        if (wpend_reg && dv0_done)
        begin
            wa_reg <= q0[29:0];
            wb_reg <= q1[29:0];
        end
        if ((state_reg == S_SQRT) && sq_done)
        begin
            dist_reg <= sq_root;
        end
        if ((state_reg == S_DIVNW) && dv0_done)
        begin
            nx_reg <= sgx_reg ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
            ny_reg <= sgy_reg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
        end
        if ((state_reg == S_MAC) && !ph_reg)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if ((state_reg == S_MAC) && ph_reg)
        begin
            acc_reg <= sum;
            case (stp_reg)
                ST_SQ_Y: s_reg   <= sum[62:0];
                ST_AN_Y: van_reg <= sh30[33:0];
                ST_AT_Y: vat_reg <= sh30[33:0];
                ST_BN_Y: vbn_reg <= sh30[33:0];
                ST_BT_Y: vbt_reg <= sh30[33:0];
                ST_MA_1:
                begin
                    nan_reg <= (mix_a > LIM_POS) ? LIM_POS[33:0]
                             : (mix_a < LIM_NEG) ? LIM_NEG[33:0] : mix_a[33:0];
                end
                ST_MB_1:
                begin
                    nbn_reg <= (mix_b > LIM_POS) ? LIM_POS[33:0]
                             : (mix_b < LIM_NEG) ? LIM_NEG[33:0] : mix_b[33:0];
                end
                ST_XA_1: vxa_reg <= sat32(sh30);
                ST_YA_1: vya_reg <= sat32(sh30);
                ST_XB_1: vxb_reg <= sat32(sh30);
                ST_YB_1: vyb_reg <= sat32(sh30);
                default: acc_reg <= sum;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign new_vel_x = new_vel_x_reg;
    assign new_vel_y = new_vel_y_reg;
    assign last_body = last_body_reg;

endmodule

FILE: test/pairwise_box_collision_response_core_test.sv
// Self-checking bench for pairwise_box_collision_response_core: loads bodies, requests
// collision passes and checks every reported velocity word against an in-bench model.
// Depends on pbc_pkg and the core RTL only.
`timescale 1ns / 100ps

module pairwise_box_collision_response_core_test;

    localparam int SLOTS = pbc_pkg::MAX_BODIES_DEF;
    localparam bit REQ_LOAD = 1'b0;
    localparam bit REQ_RUN  = 1'b1;

    typedef struct {
        bit        rt;
        bit [4:0]  idx;
        bit [5:0]  cnt;
        bit [31:0] px, py, vx, vy;
        bit [30:0] m, hw, hh;
    } cmd_t;

    typedef struct {
        bit [4:0]  idx;
        bit [31:0] vx, vy;
        bit        last;
    } vel_word_t;

    class collision_scoreboard;
        bit [31:0] px[SLOTS], py[SLOTS], vx[SLOTS], vy[SLOTS];
        bit [30:0] m[SLOTS], hw[SLOTS], hh[SLOTS];
        vel_word_t due[$];
        int errors, words, loads, runs;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function longint unsigned root(longint unsigned s);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s) b >>= 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s -= r + b;
                    r = (r >> 1) + b;
                end
                else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function bit [31:0] sat(longint v);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function longint clamp(longint v);
            longint lim;
            lim = 64'sd1 << 32;
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function void collide(int a, int b);
            longint dx, dy, ovx, ovy, nx, ny, tx, ty, wa, wb, msum;
            longint vax, vay, vbx, vby, van, vat, vbn, vbt, na, nb;
            longint unsigned ux, uy, span;
            dx = longint'($signed(px[a])) - longint'($signed(px[b]));
            dy = longint'($signed(py[a])) - longint'($signed(py[b]));
            ux = dx < 0 ? -dx : dx;
            uy = dy < 0 ? -dy : dy;
            ovx = longint'(hw[a]) + longint'(hw[b]) - longint'(ux);
            ovy = longint'(hh[a]) + longint'(hh[b]) - longint'(uy);
            if (ovx <= 0 || ovy <= 0) return;
            if (ux == 0 && uy == 0) return;
            while ((ux | uy) >= (64'd1 << 31)) begin
                ux >>= 1;
                uy >>= 1;
            end
            span = root(ux * ux + uy * uy);
            if (span == 0) return;
            nx = longint'((ux << 30) / span);
            ny = longint'((uy << 30) / span);
            if (dx < 0) nx = -nx;
            if (dy < 0) ny = -ny;
            tx = -ny;
            ty = nx;
            vax = longint'($signed(vx[a]));
            vay = longint'($signed(vy[a]));
            vbx = longint'($signed(vx[b]));
            vby = longint'($signed(vy[b]));
            van = (vax * nx + vay * ny) >>> 30;
            vat = (vax * tx + vay * ty) >>> 30;
            vbn = (vbx * nx + vby * ny) >>> 30;
            vbt = (vbx * tx + vby * ty) >>> 30;
            msum = longint'(m[a]) + longint'(m[b]);
            if (msum == 0) begin
                wa = 64'sd1 << 28;
                wb = wa;
            end
            else begin
                wa = (longint'(m[a]) << 29) / msum;
                wb = (longint'(m[b]) << 29) / msum;
            end
            na = clamp(van + (((vbn - van) * wb) >>> 28));
            nb = clamp(vbn + (((van - vbn) * wa) >>> 28));
            vx[a] = sat((na * nx + vat * tx) >>> 30);
            vy[a] = sat((na * ny + vat * ty) >>> 30);
            vx[b] = sat((nb * nx + vbt * tx) >>> 30);
            vy[b] = sat((nb * ny + vbt * ty) >>> 30);
        endfunction

        function void note(cmd_t c);
            int n;
            vel_word_t w;
            if (c.rt == REQ_LOAD) begin
                loads++;
                if (c.idx >= SLOTS) return;
                px[c.idx] = c.px; py[c.idx] = c.py;
                vx[c.idx] = c.vx; vy[c.idx] = c.vy;
                m[c.idx] = c.m; hw[c.idx] = c.hw; hh[c.idx] = c.hh;
                return;
            end
            runs++;
            n = c.cnt > SLOTS ? SLOTS : c.cnt;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    collide(i, j);
            for (int i = 0; i < n; i++) begin
                w.idx = i[4:0];
                w.vx = vx[i];
                w.vy = vy[i];
                w.last = (i + 1 == n);
                due.insert(due.size(), w);
            end
        endfunction

        task check(vel_word_t got);
            vel_word_t e;
            words++;
            if (due.size() == 0) begin
                report($sformatf("unexpected word for body %0d", got.idx));
                return;
            end
            e = due.pop_front();
            if (got.idx != e.idx)
                report($sformatf("out_index %0d, want %0d", got.idx, e.idx));
            if (got.vx != e.vx)
                report($sformatf("body %0d new_vel_x %h, want %h", e.idx, got.vx, e.vx));
            if (got.vy != e.vy)
                report($sformatf("body %0d new_vel_y %h, want %h", e.idx, got.vy, e.vy));
            if (got.last != e.last)
                report($sformatf("body %0d last_body %0b, want %0b", e.idx, got.last, e.last));
        endtask
    endclass

    logic        clk, rst_n, start, busy, req_type, out_valid, last_body;
    logic [4:0]  body_index, out_index;
    logic [5:0]  body_count;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, new_vel_x, new_vel_y;
    logic [30:0] mass, half_width, half_height;

    collision_scoreboard sb = new();
    int gap_pct;
    int loaded;

    pairwise_box_collision_response_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .body_index(body_index), .body_count(body_count),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
        .mass(mass), .half_width(half_width), .half_height(half_height),
        .out_valid(out_valid), .out_index(out_index),
        .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .last_body(last_body)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cmd_t c;
        vel_word_t w;
        if (rst_n && start && !busy) begin
            c.rt = req_type; c.idx = body_index; c.cnt = body_count;
            c.px = pos_x; c.py = pos_y; c.vx = vel_x; c.vy = vel_y;
            c.m = mass; c.hw = half_width; c.hh = half_height;
            sb.note(c);
        end
        if (rst_n && out_valid) begin
            w.idx = out_index; w.vx = new_vel_x; w.vy = new_vel_y; w.last = last_body;
            sb.check(w);
        end
    end

    task send(cmd_t c);
        @(negedge clk);
        if ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_type = c.rt; body_index = c.idx; body_count = c.cnt;
        pos_x = c.px; pos_y = c.py; vel_x = c.vx; vel_y = c.vy;
        mass = c.m; half_width = c.hw; half_height = c.hh;
        start = 1'b1;
        do @(posedge clk); while (busy);
        if (c.rt == REQ_LOAD && c.idx == loaded && loaded < SLOTS) loaded++;
    endtask

    function cmd_t body(int idx, bit [31:0] x, bit [31:0] y, bit [31:0] u, bit [31:0] v,
                        bit [30:0] mm, bit [30:0] w, bit [30:0] h);
        cmd_t c;
        c.rt = REQ_LOAD; c.idx = idx[4:0]; c.cnt = 6'($urandom);
        c.px = x; c.py = y; c.vx = u; c.vy = v; c.m = mm; c.hw = w; c.hh = h;
        return c;
    endfunction

    function cmd_t run(int n);
        cmd_t c;
        c = body(0, $urandom, $urandom, $urandom, $urandom,
                 31'($urandom), 31'($urandom), 31'($urandom));
        c.rt = REQ_RUN;
        c.idx = 5'($urandom);
        c.cnt = n[5:0];
        return c;
    endfunction

    function cmd_t rand_body(int idx);
        if ($urandom_range(3) == 0)
            return body(idx, $urandom, $urandom, $urandom, $urandom,
                        31'($urandom), 31'($urandom), 31'($urandom));
        return body(idx,
            $urandom_range(8 << 16) - (4 << 16), $urandom_range(8 << 16) - (4 << 16),
            $urandom_range(32 << 16) - (16 << 16), $urandom_range(32 << 16) - (16 << 16),
            $urandom_range(5) == 0 ? 31'd0 : 31'($urandom_range(1, 1 << 20)),
            31'($urandom_range(3 << 16)), 31'($urandom_range(3 << 16)));
    endfunction

    initial
    begin
        #250ms;
        $display("pairwise_box_collision_response_core test failed");
        $finish;
    end

    initial
    begin
        int n;
        start = 1'b0; req_type = REQ_LOAD; body_index = '0; body_count = '0;
        pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0;
        mass = '0; half_width = '0; half_height = '0;
        loaded = 0;
        gap_pct = 13;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // huge boxes, extreme velocities, coincident centres, zero masses
        send(body(0, 0, 0, 32'h7fffffff, 32'h80000000, 31'd1, 31'h7fffffff, 31'h7fffffff));
        send(run(1));
        send(body(1, 0, 0, 32'h80000000, 32'h7fffffff, 31'h7fffffff,
                  31'h7fffffff, 31'h7fffffff));
        send(run(2));
        send(run(0));
        send(body(2, 32'h80000000, 32'h7fffffff, 32'h00010000, 32'hffff0000, 31'd0,
                  31'h7fffffff, 31'h7fffffff));
        send(body(3, 32'h00008000, 32'hffff8000, 32'h80000000, 32'h80000000, 31'd0,
                  31'd0, 31'd0));
        send(run(4));
        send(body(4, 32'h00010000, 32'h00010000, 32'h00020000, 0, 31'h00010000,
                  31'h00010000, 31'h00010000));
        send(body(5, 32'h00018000, 32'h00010000, 32'hfffe0000, 0, 31'h00010000,
                  31'h00010000, 31'h00010000));
        send(body(6, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                  31'd0, 31'h7fffffff));
        send(run(7));
        send(run(7));

        for (int k = 0; k < 100; k++) begin
            if (k == 33) gap_pct = 58;
            if (k == 66) gap_pct = 0;
            if ($urandom_range(99) < 60)
                send(rand_body(loaded < SLOTS && $urandom_range(2) != 0 ?
                               loaded : $urandom_range(SLOTS - 1)));
            else begin
                if (loaded == SLOTS && $urandom_range(99) < 8)
                    n = $urandom_range(SLOTS, 63);
                else
                    n = $urandom_range(loaded < 9 ? loaded : 9);
                send(run(n));
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (sb.due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.due.size() != 0)
            sb.report($sformatf("%0d words never arrived", sb.due.size()));

        $display("Covered %0d body loads and %0d collision passes, %0d velocity words checked.",
                 sb.loads, sb.runs, sb.words);
        if (sb.errors == 0)
            $display("pairwise_box_collision_response_core test passed");
        else
            $display("pairwise_box_collision_response_core test failed");
        $finish;
    end

endmodule
